FILE: rtl/svbd_pkg.sv
package svbd_pkg;

    localparam int ValueWidth = 64;
    localparam int LenWidth   = 4;

    // Kind of a classified word, as handed from the front to the back
    localparam logic [1:0] KIND_SHORT = 2'd0;  // header byte that is the value itself
    localparam logic [1:0] KIND_HDR   = 2'd1;  // header byte announcing magnitude bytes
    localparam logic [1:0] KIND_MAG   = 2'd2;  // magnitude byte
    localparam logic [1:0] KIND_ERR   = 2'd3;  // stream ended inside a value

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_TRUNC = 1'b1;

    typedef struct packed {
        logic [1:0]          kind;
        logic [7:0]          data;
        logic [LenWidth-1:0] len;   // total length for a header, bytes seen for an error
        logic                neg;   // header: invert the assembled magnitude
        logic                last;  // magnitude: final byte of the value
    } t_entry;

    function automatic logic [ValueWidth-1:0] finish_value(
        input logic [ValueWidth-1:0] v,
        input logic                  narrow
    );
        logic [ValueWidth-1:0] r;
        r = v;
        if (narrow) begin
            r = {{(ValueWidth-32){v[31]}}, v[31:0]};
        end
        return r;
    endfunction

endpackage

FILE: rtl/svbd_if.sv
interface svbd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       stream_end;

    modport source (output valid, output data_byte, output stream_end, input ready);
    modport sink (input valid, input data_byte, input stream_end, output ready);
endinterface

interface svbd_out_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] value;
    logic [3:0]         encoded_length;
    logic               status;

    modport source (output valid, output value, output encoded_length, output status,
                    input ready);
    modport sink (input valid, input value, input encoded_length, input status,
                  output ready);
endinterface

FILE: rtl/svbd_queue.sv
module svbd_queue #(
    parameter int DEPTH = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  svbd_pkg::t_entry  i_entry,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_empty,
    output svbd_pkg::t_entry  o_head
);

    localparam int PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntWidth = $clog2(DEPTH + 1);

    svbd_pkg::t_entry      r_mem [DEPTH];
    logic [PtrWidth-1:0]   r_wr_ptr;
    logic [PtrWidth-1:0]   r_rd_ptr;
    logic [CntWidth-1:0]   r_count;
    logic [PtrWidth-1:0]   n_wr_ptr;
    logic [PtrWidth-1:0]   n_rd_ptr;
    logic                  do_push;
    logic                  do_pop;

    assign o_full  = (r_count == CntWidth'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    assign n_wr_ptr = (r_wr_ptr == PtrWidth'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == PtrWidth'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntWidth'(DEPTH))
        else $error("queue count beyond depth");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == CntWidth'(DEPTH)) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with count");
`endif

endmodule

FILE: rtl/svbd_front.sv
module svbd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    svbd_in_if.sink           i_in,
    input  logic              i_full,
    output logic              o_push,
    output svbd_pkg::t_entry  o_entry
);

    logic [svbd_pkg::LenWidth-1:0] r_rem;
    logic [svbd_pkg::LenWidth-1:0] r_total;
    logic [svbd_pkg::LenWidth-1:0] n_rem;
    logic [svbd_pkg::LenWidth-1:0] n_total;
    logic [svbd_pkg::LenWidth-1:0] hdr_count;
    logic [4:0]                    hdr_count_w;
    logic                          accept;
    logic                          is_long_hdr;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && i_in.ready;

    // Long header bytes are 0x80..0x8F; the upper half of that range is positive
    assign is_long_hdr = (i_in.data_byte[7:4] == 4'h8);
    assign hdr_count_w = i_in.data_byte[3] ? (5'd16 - {2'b00, i_in.data_byte[2:0]} - 5'd8)
                                           : (5'd8 - {2'b00, i_in.data_byte[2:0]});
    assign hdr_count   = hdr_count_w[svbd_pkg::LenWidth-1:0];

    always_comb begin
        n_rem         = r_rem;
        n_total       = r_total;
        o_push        = 1'b0;
        o_entry.kind  = svbd_pkg::KIND_SHORT;
        o_entry.data  = i_in.data_byte;
        o_entry.len   = r_total;
        o_entry.neg   = !i_in.data_byte[3];
        o_entry.last  = (r_rem == svbd_pkg::LenWidth'(1));
        if (accept) begin
            priority if (i_in.stream_end) begin
                // drop an end marker between values
                if (r_rem != '0) begin
                    o_push       = 1'b1;
                    o_entry.kind = svbd_pkg::KIND_ERR;
                    o_entry.len  = r_total - r_rem;
                    n_rem        = '0;
                end
            end else if (r_rem == '0) begin
                o_push = 1'b1;
                if (is_long_hdr) begin
                    o_entry.kind = svbd_pkg::KIND_HDR;
                    o_entry.len  = hdr_count + 1'b1;
                    n_rem        = hdr_count;
                    n_total      = hdr_count + 1'b1;
                end else begin
                    o_entry.kind = svbd_pkg::KIND_SHORT;
                end
            end else begin
                o_push       = 1'b1;
                o_entry.kind = svbd_pkg::KIND_MAG;
                n_rem        = r_rem - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem   <= '0;
            r_total <= '0;
        end else begin
            r_rem   <= n_rem;
            r_total <= n_total;
        end
    end

endmodule

FILE: rtl/svbd_back.sv
module svbd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_narrow_mode,
    input  logic              i_empty,
    input  svbd_pkg::t_entry  i_head,
    output logic              o_pop,
    svbd_out_if.source        o_out
);

    localparam int VW = svbd_pkg::ValueWidth;

    logic [VW-1:0]                 r_acc;
    logic                          r_neg;
    logic [svbd_pkg::LenWidth-1:0] r_len;
    logic                          r_out_valid;
    logic [VW-1:0]                 r_out_value;
    logic [svbd_pkg::LenWidth-1:0] r_out_len;
    logic                          r_out_status;

    logic [VW-1:0]                 acc_shift;
    logic [VW-1:0]                 n_value;
    logic [svbd_pkg::LenWidth-1:0] n_len;
    logic                          n_status;
    logic                          emit;
    logic                          slot_free;

    assign slot_free = !r_out_valid || o_out.ready;
    assign o_pop     = !i_empty && slot_free;
    assign acc_shift = {r_acc[VW-9:0], i_head.data};

    always_comb begin
        emit     = 1'b0;
        n_value  = '0;
        n_len    = r_len;
        n_status = svbd_pkg::STATUS_OK;
        unique case (i_head.kind)
            svbd_pkg::KIND_SHORT: begin
                emit    = 1'b1;
                n_value = svbd_pkg::finish_value({{(VW-8){i_head.data[7]}}, i_head.data},
                                                 i_narrow_mode);
                n_len   = svbd_pkg::LenWidth'(1);
            end
            svbd_pkg::KIND_HDR: begin
                emit = 1'b0;
            end
            svbd_pkg::KIND_MAG: begin
                emit    = i_head.last;
                n_value = svbd_pkg::finish_value(r_neg ? ~acc_shift : acc_shift,
                                                 i_narrow_mode);
            end
            svbd_pkg::KIND_ERR: begin
                emit     = 1'b1;
                n_len    = i_head.len;
                n_status = svbd_pkg::STATUS_TRUNC;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            if (i_head.kind == svbd_pkg::KIND_HDR) begin
                r_acc <= '0;
                r_neg <= i_head.neg;
                r_len <= i_head.len;
            end else if (i_head.kind == svbd_pkg::KIND_MAG) begin
                r_acc <= acc_shift;
            end
        end
        if (o_pop && emit) begin
            r_out_value  <= n_value;
            r_out_len    <= n_len;
            r_out_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (slot_free) begin
            r_out_valid <= o_pop && emit;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.value          = r_out_value;
    assign o_out.encoded_length = r_out_len;
    assign o_out.status         = r_out_status;

`ifndef SYNTHESIS
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status) |-> (r_out_value == '0))
        else $error("truncation word carries a nonzero value");
    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_status) |->
        (r_out_len != '0 && r_out_len <= svbd_pkg::LenWidth'(9)))
        else $error("encoded length out of range");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |=> (r_out_valid && $stable(r_out_value)))
        else $error("stalled result changed");
`endif

endmodule

FILE: rtl/signed_varint_byte_decoder_core.sv
// Decoder for zero-compressed variable-length signed integers, one byte word per
// cycle. The front tracks how many magnitude bytes are still due and tags each
// byte as short value, header, magnitude byte or truncation; a QUEUE_DEPTH-entry
// queue carries the tags to the back, which shifts magnitude bytes into a 64-bit
// accumulator and loads the output register. The byte that ends a result (or the
// end marker that cuts it short) is queued, and the result is then registered.
// The input stays ready at full rate unless the output is stalled long enough
// to fill the queue. narrow_mode is applied when the result is formed.
module signed_varint_byte_decoder_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    svbd_in_if.sink     i_in,
    svbd_out_if.source  o_out
);

    logic             r_narrow_mode;
    logic             push;
    logic             pop;
    logic             full;
    logic             empty;
    svbd_pkg::t_entry entry;
    svbd_pkg::t_entry head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_narrow_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_narrow_mode <= i_cfg_wdata;
        end
    end

    svbd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_entry (entry)
    );

    svbd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_head  (head)
    );

    svbd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_narrow_mode (r_narrow_mode),
        .i_empty       (empty),
        .i_head        (head),
        .o_pop         (pop),
        .o_out         (o_out)
    );

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int HOLD_CYCLES    = 150;
    localparam int PHASE_WORDS    = 70;

    // headers 80..8F open a multi-byte value; the byte count is the distance to the base
    localparam logic [7:0] LONG_FIRST    = 8'h80;
    localparam logic [7:0] LONG_NEG_BASE = 8'h88;
    localparam logic [7:0] LONG_POS_BASE = 8'h90;

    typedef struct packed {
        logic [svbd_pkg::ValueWidth-1:0] value;
        logic [svbd_pkg::LenWidth-1:0]   len;
        logic                            status;
    } t_result;

    logic i_clk;
    logic i_rst_n;
    logic cfg_we;
    logic cfg_wdata;

    svbd_in_if  in_if();
    svbd_out_if out_if();

    signed_varint_byte_decoder_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    t_result expected_values[$];

    // decoder state as the bench tracks it
    logic [svbd_pkg::ValueWidth-1:0] acc_q    = '0;
    logic [svbd_pkg::LenWidth-1:0]   left_q   = '0;
    logic                            neg_q    = 1'b0;
    logic [svbd_pkg::LenWidth-1:0]   total_q  = '0;
    logic                            narrow_q = 1'b0;

    int   src_idle_pct;
    int   sink_idle_pct;
    logic hold_req;
    int   hold_left    = 0;
    int   quiet_cycles = 0;
    int   mismatches   = 0;
    int   results_seen = 0;
    int   trunc_seen   = 0;
    int   words_in     = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void expect_result(input logic [svbd_pkg::ValueWidth-1:0] v,
                                          input logic [svbd_pkg::LenWidth-1:0] len,
                                          input logic st);
        t_result r;
        r.value  = narrow_q ? {{(svbd_pkg::ValueWidth-32){v[31]}}, v[31:0]} : v;
        r.len    = len;
        r.status = st;
        expected_values.push_back(r);
    endfunction

    function automatic void decode_word(input logic [7:0] b, input logic e);
        if (e) begin
            // end marker: only matters inside a value
            if (left_q != '0) begin
                expect_result('0, total_q - left_q, svbd_pkg::STATUS_TRUNC);
                acc_q   = '0;
                left_q  = '0;
                neg_q   = 1'b0;
                total_q = '0;
            end
        end else if (left_q == '0) begin
            if (b < LONG_FIRST || b >= LONG_POS_BASE) begin
                expect_result({{(svbd_pkg::ValueWidth-8){b[7]}}, b},
                              svbd_pkg::LenWidth'(1), svbd_pkg::STATUS_OK);
            end else begin
                if (b >= LONG_NEG_BASE) begin
                    left_q = svbd_pkg::LenWidth'(LONG_POS_BASE - b);
                    neg_q  = 1'b0;
                end else begin
                    left_q = svbd_pkg::LenWidth'(LONG_NEG_BASE - b);
                    neg_q  = 1'b1;
                end
                total_q = left_q + 1'b1;
                acc_q   = '0;
            end
        end else begin
            acc_q  = {acc_q[svbd_pkg::ValueWidth-9:0], b};
            left_q = left_q - 1'b1;
            if (left_q == '0) begin
                expect_result(neg_q ? ~acc_q : acc_q, total_q, svbd_pkg::STATUS_OK);
                acc_q   = '0;
                neg_q   = 1'b0;
                total_q = '0;
            end
        end
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: %s mismatch, got %0h, want %0h", $time, field, got, want);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && in_if.valid && in_if.ready) begin
            words_in++;
            decode_word(in_if.data_byte, in_if.stream_end);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            results_seen++;
            if (out_if.status == svbd_pkg::STATUS_TRUNC)
                trunc_seen++;
            if (expected_values.size() == 0) begin
                report_mismatch("unexpected result, value", out_if.value, '0);
            end else begin
                want = expected_values.pop_front();
                if (out_if.value !== want.value)
                    report_mismatch("value", out_if.value, want.value);
                if (out_if.encoded_length !== want.len)
                    report_mismatch("encoded_length", 64'(out_if.encoded_length),
                                    64'(want.len));
                if (out_if.status !== want.status)
                    report_mismatch("status", 64'(out_if.status), 64'(want.status));
            end
        end
    end

    // output side: random stalls, or one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            out_if.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else if (hold_req) begin
            out_if.ready <= 1'b0;
            hold_left    <= HOLD_CYCLES;
            hold_req     <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    task automatic send_word(input logic [7:0] b, input logic e);
        while ($urandom_range(99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.data_byte  <= b;
        in_if.stream_end <= e;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    task automatic wait_idle();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_values.size() != 0) @(posedge i_clk);
        // end markers between values leave no result to wait for
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_narrow(input logic m);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        narrow_q = m;
    endtask

    task automatic send_random_value(inout int words);
        int         kind;
        int         cnt;
        logic [7:0] b;
        kind = $urandom_range(99);
        if (kind < 30) begin
            b = 8'($urandom_range(239));
            if (b >= LONG_FIRST)
                b = b + 8'd16;
            send_word(b, 1'b0);
            words++;
        end else if (kind < 96) begin
            cnt = $urandom_range(8, 1);
            b   = $urandom_range(1) ? 8'(LONG_NEG_BASE - cnt) : 8'(LONG_POS_BASE - cnt);
            send_word(b, 1'b0);
            words++;
            for (int i = 0; i < cnt; i++) begin
                if ($urandom_range(99) < 4) begin
                    // cut the value short
                    send_word(8'($urandom), 1'b1);
                    words++;
                    return;
                end
                send_word(8'($urandom), 1'b0);
                words++;
            end
        end else begin
            send_word(8'($urandom), 1'b1);
            words++;
        end
    endtask

    task automatic test_short_values();
        send_word(8'h00, 1'b0);
        send_word(8'h7F, 1'b0);
        send_word(8'h90, 1'b0);
        send_word(8'hFF, 1'b0);
    endtask

    task automatic test_long_values();
        // largest positive, then the inverted form giving the most negative
        send_word(LONG_POS_BASE - 8'd8, 1'b0);
        send_word(8'h7F, 1'b0);
        repeat (7) send_word(8'hFF, 1'b0);
        send_word(LONG_NEG_BASE - 8'd8, 1'b0);
        send_word(8'h7F, 1'b0);
        repeat (7) send_word(8'hFF, 1'b0);
    endtask

    task automatic test_stream_end();
        send_word(8'hA5, 1'b1);
        send_word(LONG_POS_BASE - 8'd3, 1'b0);
        send_word(8'h12, 1'b0);
        send_word(8'h5A, 1'b1);
    endtask

    task automatic test_narrow_mode();
        set_narrow(1'b1);
        send_word(LONG_POS_BASE - 8'd4, 1'b0);
        send_word(8'h80, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'h01, 1'b0);
        set_narrow(1'b0);
    endtask

    task automatic test_backpressure();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        hold_req <= 1'b1;
        repeat (40) send_word(8'($urandom_range(127)), 1'b0);
        wait_idle();
    endtask

    task automatic test_random();
        int words;
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    src_idle_pct  = 31;
                    sink_idle_pct = 45;
                end
                1: begin
                    src_idle_pct  = 45;
                    sink_idle_pct = 31;
                end
                default: begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase
            for (int m = 0; m < 2; m++) begin
                set_narrow(m[0]);
                words = 0;
                while (words < PHASE_WORDS) send_random_value(words);
            end
        end
    endtask

    initial begin
        i_rst_n           = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = 1'b0;
        in_if.valid       = 1'b0;
        in_if.data_byte   = 8'h00;
        in_if.stream_end  = 1'b0;
        out_if.ready      = 1'b0;
        hold_req          = 1'b0;
        src_idle_pct      = 31;
        sink_idle_pct     = 45;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_short_values();
        test_long_values();
        test_stream_end();
        test_narrow_mode();
        test_backpressure();
        test_random();
        wait_idle();

        $display("Run covered %0d input words and %0d decoded results (%0d truncated),",
                 words_in, results_seen, trunc_seen);
        $display("both width modes, idle and stall on each side and a long output hold-off.");
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
